// ===== rtl/core/s2dc_pkg.sv =====
// Shared types and constants for the stride-2 convolution core.
package s2dc_pkg;

  localparam int unsigned MaxWidthDef    = 256;
  localparam int unsigned MaxHeightDef   = 256;
  localparam int unsigned MaxChannelsDef = 1024;
  localparam int unsigned MaxKernelDef   = 7;

  localparam int unsigned AccDepth = 16384;
  localparam int unsigned AccAw    = 14;
  localparam int unsigned CfgAw    = 3;
  localparam int unsigned CfgDw    = 11;

  localparam logic signed [47:0] AccMax = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] AccMin = 48'sh8000_0000_0000;

  typedef enum logic [1:0] {
    ModeWeight  = 2'd0,
    ModePreload = 2'd1,
    ModePixel   = 2'd2,
    ModeNone    = 2'd3
  } mode_e;

  typedef enum logic [CfgAw-1:0] {
    RegKsel   = 3'd0,
    RegInW    = 3'd1,
    RegInH    = 3'd2,
    RegOutW   = 3'd3,
    RegOutH   = 3'd4,
    RegInCh   = 3'd5
  } reg_e;

  typedef struct packed {
    logic [1:0]         mode;
    logic [5:0]         tap_index;
    logic [13:0]        target_index;
    logic signed [15:0] sample;
    logic signed [47:0] preload_value;
  } in_word_t;

  typedef struct packed {
    logic [13:0]        result_index;
    logic signed [47:0] result_value;
    logic               last;
  } out_word_t;

  // MAC unit control from the sequencer
  typedef struct packed {
    logic clear;
    logic step;
  } mac_ctl_t;

  function automatic logic [2:0] ksize(input logic [1:0] sel);
    case (sel)
      2'd0:    ksize = 3'd2;
      2'd1:    ksize = 3'd3;
      2'd2:    ksize = 3'd5;
      default: ksize = 3'd7;
    endcase
  endfunction

endpackage

// ===== rtl/core/s2dc_mac.sv =====
// Shared 16x16 multiply-accumulate unit with registered product.
module s2dc_mac (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  s2dc_pkg::mac_ctl_t      ctl_i,
  input  logic signed [15:0]      a_i,
  input  logic signed [15:0]      b_i,
  output logic signed [37:0]      dot_o
);
  import s2dc_pkg::*;

  logic signed [31:0] prod_q, prod_d;
  logic               pv_q, pv_d;
  logic signed [37:0] dot_q, dot_d;

  always_comb begin
    prod_d = a_i * b_i;
    pv_d   = ctl_i.step;
    dot_d  = dot_q;
    if (pv_q) begin
      dot_d = dot_q + 38'(prod_q);
    end
    if (ctl_i.clear) begin
      dot_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else begin
      pv_q <= pv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    dot_q  <= dot_d;
  end

  assign dot_o = dot_q;
endmodule

// ===== rtl/core/stride2_direct_convolution_core.sv =====
// Top level of the stride-2 direct convolution core.
// One word is taken at a time. Weight words, preloads and pixel words that
// close no window go through the execute state and back to idle. A pixel
// word that closes a window of K x K taps goes on to the tap walk. The
// single shared multiply-accumulate unit walks the taps one a cycle through
// the kernel memory and the line memory (one read port each). A MAC pipeline
// drain follows, then one read-modify-write of the accumulator memory. About
// one pixel in four closes a window. A result word sits in an output
// register, and new words are taken while it waits. A later window with a
// result to emit holds in its write-back state until that register is free,
// so a stalled result adds its stall to that window. Row mod K comes from a
// reciprocal multiply, exact for rows below 4096. Accumulators, line and
// kernel memories have no reset and must be written before use. No clearing
// pass after reset.
module stride2_direct_convolution_core #(
  parameter int unsigned MAX_WIDTH    = s2dc_pkg::MaxWidthDef,
  parameter int unsigned MAX_HEIGHT   = s2dc_pkg::MaxHeightDef,
  parameter int unsigned MAX_CHANNELS = s2dc_pkg::MaxChannelsDef,
  parameter int unsigned MAX_KERNEL   = s2dc_pkg::MaxKernelDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [s2dc_pkg::CfgAw-1:0]    cfg_idx_i,
  input  logic [s2dc_pkg::CfgDw-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  s2dc_pkg::in_word_t            in_word_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output s2dc_pkg::out_word_t           out_word_o
);
  import s2dc_pkg::*;

  localparam int unsigned KsDepth = MAX_KERNEL * MAX_KERNEL;
  localparam int unsigned KsAw    = $clog2(KsDepth);
  localparam int unsigned WAw     = $clog2(MAX_WIDTH);
  localparam int unsigned HAw     = $clog2(MAX_HEIGHT);
  localparam int unsigned ChAw    = $clog2(MAX_CHANNELS + 1);
  localparam int unsigned LnDepth = MAX_KERNEL * MAX_WIDTH;
  localparam int unsigned LnAw    = $clog2(LnDepth);

  // configuration
  logic [1:0]  ksel_q;
  logic [8:0]  inw_q, inh_q;
  logic [7:0]  outw_q, outh_q;
  logic [10:0] inch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ksel_q <= 2'd1;
      inw_q  <= 9'd256;
      inh_q  <= 9'd256;
      outw_q <= 8'd127;
      outh_q <= 8'd127;
      inch_q <= 11'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegKsel: ksel_q <= cfg_data_i[1:0];
        RegInW:  inw_q  <= cfg_data_i[8:0];
        RegInH:  inh_q  <= cfg_data_i[8:0];
        RegOutW: outw_q <= cfg_data_i[7:0];
        RegOutH: outh_q <= cfg_data_i[7:0];
        RegInCh: inch_q <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  // effective sizes, clamped
  logic [2:0]  k;
  logic [31:0] iw, ih, ic;
  always_comb begin
    k  = (ksize(ksel_q) > 3'(MAX_KERNEL)) ? 3'(MAX_KERNEL) : ksize(ksel_q);
    iw = (inw_q == 9'd0) ? 32'd1 : ((32'(inw_q) > MAX_WIDTH) ? MAX_WIDTH : 32'(inw_q));
    ih = (inh_q == 9'd0) ? 32'd1 : ((32'(inh_q) > MAX_HEIGHT) ? MAX_HEIGHT : 32'(inh_q));
    ic = (inch_q == 11'd0) ? 32'd1 :
         ((32'(inch_q) > MAX_CHANNELS) ? MAX_CHANNELS : 32'(inch_q));
  end

  // sequencer states
  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StExec  = 5'b00010,
    StTaps  = 5'b00100,
    StDrain = 5'b01000,
    StAcc   = 5'b10000
  } state_e;

  state_e state_q, state_d;
  in_word_t word_q;
  logic [WAw-1:0] col_q;
  logic [HAw-1:0] row_q;
  logic [ChAw-1:0] ch_q;
  logic [2:0] ti_q, tj_q;   // tap row / column
  logic [2:0] lr_q;         // line row of tap row
  logic [2:0] drain_q;
  logic [WAw-1:0] left_q;
  logic [AccAw-1:0] addr_q;
  logic emit_q, lastf_q;
  out_word_t out_q;
  logic out_v_q, out_v_d;

  // memories
  logic signed [15:0] kmem [KsDepth];
  logic signed [15:0] lmem [LnDepth];
  logic signed [47:0] amem [AccDepth];
  logic signed [15:0] krd_q, lrd_q;
  logic signed [47:0] ard_q;

  // window check on the current pixel
  logic [31:0] r32, c32, top, left;
  logic win_ok;
  always_comb begin
    r32 = 32'(row_q);
    c32 = 32'(col_q);
    top  = r32 + 32'd1 - 32'(k);
    left = c32 + 32'd1 - 32'(k);
    win_ok = (r32 + 32'd1 >= 32'(k)) && (c32 + 32'd1 >= 32'(k)) &&
             !top[0] && !left[0] &&
             ((top >> 1) < 32'(outh_q)) && ((left >> 1) < 32'(outw_q));
  end

  // row mod k: quotient by reciprocal multiply, then one subtract
  logic [31:0] rquot;
  logic [2:0]  rmod, rnext;
  always_comb begin
    case (k)
      3'd3:    rquot = (r32 * 32'd2731) >> 13;
      3'd5:    rquot = (r32 * 32'd3277) >> 14;
      3'd7:    rquot = (r32 * 32'd4682) >> 15;
      default: rquot = r32 >> 1;
    endcase
    rmod  = 3'(r32 - rquot * 32'(k));
    // line row of the window's top row: (row + 1) mod k
    rnext = (rmod == k - 3'd1) ? 3'd0 : rmod + 3'd1;
  end

  // tap addressing
  logic [KsAw-1:0] kaddr;
  logic [LnAw-1:0] laddr;
  always_comb begin
    kaddr = KsAw'(32'(ti_q) * 32'(k) + 32'(tj_q));
    laddr = LnAw'(32'(lr_q) * MAX_WIDTH + 32'(left_q) + 32'(tj_q));
  end

  mac_ctl_t mac_ctl;
  logic signed [37:0] dot;
  s2dc_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .a_i    (krd_q),
    .b_i    (lrd_q),
    .dot_o  (dot)
  );

  logic kv_q; // memory read data of taps valid this cycle
  logic tap_last;
  assign tap_last = (ti_q == k - 3'd1) && (tj_q == k - 3'd1);

  always_comb begin
    mac_ctl.clear = (state_q == StExec);
    mac_ctl.step  = kv_q;
  end

  logic signed [48:0] sum;
  logic signed [47:0] sat;
  always_comb begin
    sum = 49'(ard_q) + 49'(dot);
    if (sum > 49'(AccMax))      sat = AccMax;
    else if (sum < 49'(AccMin)) sat = AccMin;
    else                        sat = sum[47:0];
  end

  // write-back goes ahead once the result register is free (or nothing to emit)
  logic out_free, acc_go;
  assign out_free = !out_v_q || out_ready_i;
  assign acc_go   = (state_q == StAcc) && (!emit_q || out_free);

  always_comb begin
    out_v_d = out_v_q && !out_ready_i;
    if (acc_go && emit_q) out_v_d = 1'b1;
  end

  assign in_ready_o = (state_q == StIdle);
  assign out_valid_o = out_v_q;
  assign out_word_o = out_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (in_valid_i && in_ready_o) state_d = StExec;
      StExec:  state_d = (word_q.mode == ModePixel && win_ok) ? StTaps : StIdle;
      StTaps:  if (tap_last) state_d = StDrain;
      StDrain: if (drain_q == 3'd2) state_d = StAcc;
      StAcc:   if (acc_go) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      col_q   <= '0;
      row_q   <= '0;
      ch_q    <= '0;
      out_v_q <= 1'b0;
      kv_q    <= 1'b0;
      ti_q <= '0; tj_q <= '0; lr_q <= '0; drain_q <= '0;
    end else begin
      state_q <= state_d;
      kv_q    <= (state_q == StTaps);
      out_v_q <= out_v_d;
      unique case (state_q)
        StExec: begin
          ti_q <= '0; tj_q <= '0; drain_q <= '0;
          lr_q <= rnext;
          if (word_q.mode == ModePixel) begin
            if (c32 + 32'd1 >= iw) begin
              col_q <= '0;
              if (r32 + 32'd1 >= ih) begin
                row_q <= '0;
                ch_q  <= (32'(ch_q) + 32'd1 >= ic) ? '0 : ch_q + ChAw'(1);
              end else begin
                row_q <= row_q + HAw'(1);
              end
            end else begin
              col_q <= col_q + WAw'(1);
            end
          end
        end
        StTaps: begin
          if (tj_q == k - 3'd1) begin
            tj_q <= '0;
            ti_q <= ti_q + 3'd1;
            lr_q <= (lr_q == k - 3'd1) ? 3'd0 : lr_q + 3'd1;
          end else begin
            tj_q <= tj_q + 3'd1;
          end
        end
        StDrain: drain_q <= drain_q + 3'd1;
        default: ;
      endcase
    end
  end

  // datapath registers and memories
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && in_valid_i && in_ready_o) begin
      word_q <= in_word_i;
    end
    if (state_q == StExec) begin
      left_q <= WAw'(left);
      emit_q <= 32'(ch_q) + 32'd1 >= ic;
      lastf_q <= ((top >> 1) + 32'd1 == 32'(outh_q)) && ((left >> 1) + 32'd1 == 32'(outw_q));
      addr_q <= AccAw'((top >> 1) * 32'(outw_q) + (left >> 1));
      unique case (mode_e'(word_q.mode))
        ModeWeight:  if (32'(word_q.tap_index) < KsDepth)
                       kmem[KsAw'(word_q.tap_index)] <= word_q.sample;
        ModePreload: amem[word_q.target_index] <= word_q.preload_value;
        ModePixel:   lmem[LnAw'(32'(rmod) * MAX_WIDTH + c32)] <= word_q.sample;
        default: ;
      endcase
    end
    krd_q <= kmem[kaddr];
    lrd_q <= lmem[laddr];
    ard_q <= amem[addr_q];
    if (acc_go) begin
      amem[addr_q] <= sat;
    end
    if (acc_go && emit_q) begin
      out_q.result_index <= addr_q;
      out_q.result_value <= sat;
      out_q.last         <= lastf_q;
    end
  end
endmodule

// ===== rtl/core/s2dc_checker.sv =====
// Port-level checks for the stride-2 convolution core.
module s2dc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input s2dc_pkg::in_word_t  in_word_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input s2dc_pkg::out_word_t out_word_o
);
  import s2dc_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word dropped or changed while stalled");

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready right after accepting a word");

  a_out_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !$isunknown(out_word_o))
    else $error("result word carries unknown bits");

  a_no_out_from_weight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_word_i.mode != ModePixel |=> ##1 !$rose(out_valid_o))
    else $error("result from non-pixel word");
endmodule

bind stride2_direct_convolution_core s2dc_checker u_s2dc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_word_o  (out_word_o)
);

// ===== dv/tb_stride2_direct_convolution_core.sv =====
// Self-checking testbench for the stride-2 direct convolution core.
module tb_stride2_direct_convolution_core;
  import s2dc_pkg::*;

  localparam int unsigned CycleLimit = 4_000_000;
  localparam int unsigned DrainWait  = 80;   // > one 7x7 window plus output hand-off
  localparam int unsigned RandWords  = 200;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we = 1'b0;
  logic [CfgAw-1:0]  cfg_idx = '0;
  logic [CfgDw-1:0]  cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  in_word_t          in_word = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_word_t         out_word;

  always #2 clk_i = ~clk_i;

  stride2_direct_convolution_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: its own copy of the registers, stores and counters.
  // ---------------------------------------------------------------------------
  logic [1:0]         ksel_q = 2'd1;
  logic [8:0]         inw_q = 9'd256, inh_q = 9'd256;
  logic [7:0]         outw_q = 8'd127, outh_q = 8'd127;
  logic [10:0]        inch_q = 11'd1;
  logic signed [15:0] taps[49];
  logic signed [15:0] lines[7*256];
  logic signed [47:0] sums[AccDepth];
  int unsigned        col_q, row_q, chan_q;

  out_word_t          pending[$];   // results still owed by the core
  int unsigned        errors, cycles, rand_sent;
  bit                 calm, rand_phase;
  int unsigned        stall_left;

  function automatic int unsigned clip(int unsigned v, int unsigned hi);
    return (v == 0) ? 1 : ((v > hi) ? hi : v);
  endfunction

  function automatic int unsigned kdim(logic [1:0] sel);
    case (sel)
      2'd0:    return 2;
      2'd1:    return 3;
      2'd2:    return 5;
      default: return 7;
    endcase
  endfunction

  // Applies one accepted word; returns 1 with the finished sum when a window
  // on the last channel lands inside the output plane.
  function automatic bit conv_step(input in_word_t w, output out_word_t res);
    int unsigned k, iw, ih, ic, r, c, top, left, oy, ox;
    logic [13:0] a;
    longint dot, acc;
    bit hit;
    hit = 0;
    res = '0;
    case (mode_e'(w.mode))
      ModeWeight: begin
        if (w.tap_index < 49) taps[w.tap_index] = w.sample;
      end
      ModePreload: sums[w.target_index] = w.preload_value;
      ModePixel: begin
        k  = kdim(ksel_q);
        iw = clip(inw_q, 256);
        ih = clip(inh_q, 256);
        ic = clip(inch_q, 1024);
        r  = row_q;
        c  = (col_q >= 256) ? 0 : col_q;
        lines[(r % k) * 256 + c] = w.sample;
        if (r + 1 >= k && c + 1 >= k) begin
          top  = r + 1 - k;
          left = c + 1 - k;
          if (top[0] == 1'b0 && left[0] == 1'b0) begin
            oy = top >> 1;
            ox = left >> 1;
            if (oy < outh_q && ox < outw_q) begin
              a   = 14'(oy * outw_q + ox);
              dot = 0;
              for (int i = 0; i < k; i++)
                for (int j = 0; j < k; j++)
                  dot += longint'(taps[i*k+j]) *
                         longint'(lines[((top + i) % k) * 256 + left + j]);
              acc = longint'(sums[a]) + dot;
              if (acc > longint'(AccMax)) acc = longint'(AccMax);
              if (acc < longint'(AccMin)) acc = longint'(AccMin);
              sums[a] = acc[47:0];
              if (chan_q + 1 >= ic) begin
                res.result_index = a;
                res.result_value = acc[47:0];
                res.last = (oy + 1 == outh_q && ox + 1 == outw_q);
                hit = 1;
              end
            end
          end
        end
        // raster counters: column, then row, then channel plane
        if (c + 1 >= iw) begin
          col_q = 0;
          if (r + 1 >= ih) begin
            row_q  = 0;
            chan_q = (chan_q + 1 >= ic) ? 0 : chan_q + 1;
          end else row_q = r + 1;
        end else col_q = c + 1;
      end
      default: ;
    endcase
    return hit;
  endfunction

  task automatic report(string what, longint got, longint want);
    errors++;
    $display("mismatch %s: got %0h want %0h", what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Input side: random gaps, valid held until the handshake.
  // ---------------------------------------------------------------------------
  task automatic send(input in_word_t w, input bit typed = 0,
                      input out_word_t want = '0);
    out_word_t res;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    if (conv_step(w, res)) pending.push_back(typed ? want : res);
    if (rand_phase && w.mode != ModeNone) rand_sent++;
  endtask

  function automatic in_word_t word(mode_e m, int unsigned tap, int unsigned tgt,
                                    logic [15:0] s, logic [47:0] p);
    in_word_t w;
    w.mode = m;
    w.tap_index = 6'(tap);
    w.target_index = 14'(tgt);
    w.sample = s;
    w.preload_value = p;
    return w;
  endfunction

  function automatic logic [15:0] rnd_sample();
    case ($urandom_range(0, 7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [47:0] rnd_preload();
    case ($urandom_range(0, 5))
      0:       return AccMax - 48'($urandom_range(0, 1 << 20));
      1:       return AccMin + 48'($urandom_range(0, 1 << 20));
      2:       return {16'($urandom), 32'($urandom)};
      default: return 48'(longint'(int'($urandom)));
    endcase
  endfunction

  // random word of the given mode; unused fields carry random bits too
  function automatic in_word_t rnd_word(mode_e m);
    return word(m, $urandom_range(0, 63), $urandom_range(0, 16383), rnd_sample(),
                rnd_preload());
  endfunction

  // Registers change only while the core is idle.
  task automatic set_regs(int unsigned ks, int unsigned iw, int unsigned ih,
                          int unsigned ow, int unsigned oh, int unsigned ic);
    reg_e        idx[6];
    int unsigned val[6];
    idx = '{RegKsel, RegInW, RegInH, RegOutW, RegOutH, RegInCh};
    val = '{ks, iw, ih, ow, oh, ic};
    for (int i = 0; i < 6; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= idx[i];
      cfg_data <= CfgDw'(val[i]);
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
    ksel_q = 2'(ks);
    inw_q  = 9'(iw);
    inh_q  = 9'(ih);
    outw_q = 8'(ow);
    outh_q = 8'(oh);
    inch_q = 11'(ic);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  // One convolution job: full kernel, preload of every output, then all
  // channel planes. Pixel counters are back at zero when it ends.
  task automatic run_job(int unsigned ks, int unsigned iw, int unsigned ih,
                         int unsigned ow, int unsigned oh, int unsigned ic);
    int unsigned k, n;
    set_regs(ks, iw, ih, ow, oh, ic);
    k = kdim(2'(ks));
    for (int t = 0; t < k * k; t++) send(word(ModeWeight, t, $urandom, rnd_sample(),
                                              rnd_preload()));
    for (int a = 0; a < ow * oh; a++)
      send(word(ModePreload, $urandom, a, rnd_sample(), rnd_preload()));
    n = clip(ic, 1024) * clip(iw, 256) * clip(ih, 256);
    for (int p = 0; p < n; p++) begin
      // occasional noise in the stream: stray preloads, weights, idle mode
      if ($urandom_range(0, 19) == 0) begin
        case ($urandom_range(0, 2))
          0: send(rnd_word(ModeNone));
          1: send(rnd_word(ModePreload));
          default: send(word(ModeWeight, $urandom_range(0, 63), 0, rnd_sample(), 0));
        endcase
      end
      if (rand_sent > RandWords - 150) calm = 1;
      send(rnd_word(ModePixel));
    end
    drain();
  endtask

  typedef struct {
    in_word_t  w;
    bit        typed;
    out_word_t want;
  } step_t;

  // ---------------------------------------------------------------------------
  // Output side: ready drops in random bursts.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 5);
      out_ready <= 1'b0;
    end else out_ready <= 1'b1;
  end

  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (pending.size() == 0) report("unexpected word", out_word.result_index, 0);
      else begin
        want = pending.pop_front();
        if (out_word.result_index != want.result_index)
          report("result_index", out_word.result_index, want.result_index);
        if (out_word.result_value != want.result_value)
          report("result_value", out_word.result_value, want.result_value);
        if (out_word.last != want.last) report("last", out_word.last, want.last);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    step_t steps[$];
    int unsigned k, iw, ih;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: 2x2 kernel on a 2x2 plane, one output that is also the last.
    set_regs(0, 2, 2, 1, 1, 1);
    for (int t = 0; t < 4; t++) steps.push_back('{word(ModeWeight, t, 0, 16'h7FFF, 0), 0, '0});
    steps.push_back('{word(ModeWeight, 63, 0, 16'h0000, 0), 0, '0});  // tap past store
    steps.push_back('{word(ModeNone, 0, 0, 16'h1234, 0), 0, '0});     // idle mode
    steps.push_back('{word(ModePreload, 0, 0, 0, AccMax), 0, '0});
    for (int p = 0; p < 4; p++)
      steps.push_back('{word(ModePixel, 0, 0, 16'h7FFF, 0), p == 3, '{14'd0, AccMax, 1'b1}});
    steps.push_back('{word(ModePreload, 0, 0, 0, AccMin), 0, '0});
    for (int p = 0; p < 4; p++)
      steps.push_back('{word(ModePixel, 63, 16383, 16'h8000, AccMax), p == 3,
                        '{14'd0, AccMin, 1'b1}});
    steps.push_back('{word(ModePreload, 0, 0, 0, 0), 0, '0});
    for (int p = 0; p < 4; p++)
      steps.push_back('{word(ModePixel, 0, 0, 16'(p + 1), 0), 0, '0});
    steps.push_back('{word(ModeWeight, 48, 0, 16'h8000, 0), 0, '0});
    steps.push_back('{word(ModePreload, 0, 16383, 0, 48'h0123_4567_89AB), 0, '0});
    foreach (steps[i]) send(steps[i].w, steps[i].typed, steps[i].want);
    drain();

    // Register extremes and clamping.
    run_job(0, 511, 2, 128, 1, 1);     // width clamps to 256, widest output row
    run_job(3, 9, 9, 2, 2, 2);         // 7x7 over two channels
    run_job(1, 0, 3, 1, 1, 1);         // zero width clamps to one: no windows
    run_job(1, 4, 0, 1, 1, 1);         // zero height clamps to one: no windows
    run_job(0, 2, 2, 1, 1, 0);         // zero channel count clamps to one
    run_job(1, 5, 5, 1, 1, 1);         // windows outside a 1x1 output plane

    // Random jobs on small planes.
    rand_phase = 1;
    while (rand_sent < RandWords) begin
      k  = $urandom_range(0, 3);
      iw = $urandom_range(kdim(2'(k)), 8);
      ih = $urandom_range(kdim(2'(k)), 8);
      run_job(k, iw, ih, $urandom_range(0, (iw - kdim(2'(k))) / 2 + 2),
              $urandom_range(0, (ih - kdim(2'(k))) / 2 + 2), $urandom_range(1, 2));
    end

    if (errors == 0 && pending.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/s2dc_pkg.sv
rtl/core/s2dc_mac.sv
rtl/core/stride2_direct_convolution_core.sv
rtl/core/s2dc_checker.sv
dv/tb_stride2_direct_convolution_core.sv
